[sv/json_string_unescape_utf8_unit_assert.svh]
// Assertion macros for the JSON string unescape unit.
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define JSU_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define JSU_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/jsu_pkg.sv]
// Shared types, codes and constants for the JSON string unescape unit.
package jsu_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [1:0] OP_RAW = 2'd0;
	localparam logic [1:0] OP_CP  = 2'd1;
	localparam logic [1:0] OP_END = 2'd2;
	localparam logic [1:0] OP_ERR = 2'd3;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
	localparam logic [2:0] ERR_BAD_ESC  = 3'd2;
	localparam logic [2:0] ERR_BAD_HEX  = 3'd3;
	localparam logic [2:0] ERR_BAD_SURR = 3'd4;
	localparam logic [2:0] ERR_CTRL     = 3'd5;
	localparam logic [2:0] ERR_NUL      = 3'd6;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  err;
		logic [20:0] val;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

[sv/jsu_front.sv]
// Front end: parses input bytes and issues output requests to the queue.
module jsu_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	input  jsu_pkg::qstat_t q_stat,
	output logic           q_push,
	output jsu_pkg::cmd_t  q_cmd
);
	import jsu_pkg::*;

	localparam logic [2:0] M_IDLE    = 3'd0;
	localparam logic [2:0] M_STR     = 3'd1;
	localparam logic [2:0] M_ESC     = 3'd2;
	localparam logic [2:0] M_HEX1    = 3'd3;
	localparam logic [2:0] M_WANT_BS = 3'd4;
	localparam logic [2:0] M_WANT_U  = 3'd5;
	localparam logic [2:0] M_HEX2    = 3'd6;

	function automatic cmd_t mk_cmd(input logic [1:0] op, input logic [2:0] err,
			input logic [20:0] val);
		cmd_t c;
		c.op  = op;
		c.err = err;
		c.val = val;
		return c;
	endfunction

	logic [2:0]  mode_q, mode_n;
	logic [11:0] acc_q, acc_n;
	logic [1:0]  cnt_q, cnt_n;
	logic [9:0]  hs_q, hs_n;
	logic        has_cmd, clr, is_hex, accept;
	logic [3:0]  dig;
	logic [15:0] unit;
	cmd_t        cmd;

	always_comb begin
		is_hex = 1'b1;
		dig    = in_byte[3:0];
		if (in_byte inside {[8'h30:8'h39]}) begin
			dig = in_byte[3:0];
		end else if (in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			dig = in_byte[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
	end

	assign unit = {acc_q, dig};

	always_comb begin
		mode_n  = mode_q;
		acc_n   = acc_q;
		cnt_n   = cnt_q;
		hs_n    = hs_q;
		has_cmd = 1'b0;
		clr     = 1'b0;
		cmd     = mk_cmd(OP_RAW, ERR_NONE, 21'd0);
		case (mode_q)
			M_IDLE: begin
				if (in_byte inside {8'h20, 8'h09, 8'h0A, 8'h0D}) begin
					mode_n = M_IDLE;
				end else if (in_byte == 8'h22) begin
					mode_n = M_STR;
				end else begin
					has_cmd = 1'b1;
					clr     = 1'b1;
					cmd     = mk_cmd(OP_ERR, ERR_NO_QUOTE, 21'd0);
				end
			end
			M_STR: begin
				if (in_byte == 8'h00) begin
					has_cmd = 1'b1;
					clr     = 1'b1;
					cmd     = mk_cmd(OP_ERR, ERR_NUL, 21'd0);
				end else if (in_byte == 8'h22) begin
					has_cmd = 1'b1;
					clr     = 1'b1;
					cmd     = mk_cmd(OP_END, ERR_NONE, 21'd0);
				end else if (in_byte == 8'h5C) begin
					mode_n = M_ESC;
				end else if (in_byte < 8'h20) begin
					has_cmd = 1'b1;
					clr     = 1'b1;
					cmd     = mk_cmd(OP_ERR, ERR_CTRL, 21'd0);
				end else begin
					has_cmd = 1'b1;
					cmd     = mk_cmd(OP_RAW, ERR_NONE, {13'd0, in_byte});
				end
			end
			M_ESC: begin
				has_cmd = 1'b1;
				mode_n  = M_STR;
				case (in_byte)
					8'h00: begin
						clr = 1'b1;
						cmd = mk_cmd(OP_ERR, ERR_NUL, 21'd0);
					end
					8'h22, 8'h5C, 8'h2F: cmd = mk_cmd(OP_RAW, ERR_NONE, {13'd0, in_byte});
					8'h62: cmd = mk_cmd(OP_RAW, ERR_NONE, 21'h08);
					8'h66: cmd = mk_cmd(OP_RAW, ERR_NONE, 21'h0C);
					8'h6E: cmd = mk_cmd(OP_RAW, ERR_NONE, 21'h0A);
					8'h72: cmd = mk_cmd(OP_RAW, ERR_NONE, 21'h0D);
					8'h74: cmd = mk_cmd(OP_RAW, ERR_NONE, 21'h09);
					8'h75: begin
						has_cmd = 1'b0;
						mode_n  = M_HEX1;
						acc_n   = 12'd0;
						cnt_n   = 2'd0;
					end
					default: begin
						clr = 1'b1;
						cmd = mk_cmd(OP_ERR, ERR_BAD_ESC, 21'd0);
					end
				endcase
			end
			M_HEX1, M_HEX2: begin
				if (!is_hex) begin
					has_cmd = 1'b1;
					clr     = 1'b1;
					cmd     = mk_cmd(OP_ERR, ERR_BAD_HEX, 21'd0);
				end else if (cnt_q != 2'd3) begin
					acc_n = {acc_q[7:0], dig};
					cnt_n = cnt_q + 2'd1;
				end else begin
					acc_n = 12'd0;
					cnt_n = 2'd0;
					if (mode_q == M_HEX1) begin
						if (unit inside {[16'hD800:16'hDBFF]}) begin
							hs_n   = unit[9:0];
							mode_n = M_WANT_BS;
						end else if (unit inside {[16'hDC00:16'hDFFF]}) begin
							has_cmd = 1'b1;
							clr     = 1'b1;
							cmd     = mk_cmd(OP_ERR, ERR_BAD_SURR, 21'd0);
						end else if (unit == 16'd0) begin
							has_cmd = 1'b1;
							clr     = 1'b1;
							cmd     = mk_cmd(OP_ERR, ERR_NUL, 21'd0);
						end else begin
							has_cmd = 1'b1;
							mode_n  = M_STR;
							cmd     = mk_cmd(OP_CP, ERR_NONE, {5'd0, unit});
						end
					end else begin
						has_cmd = 1'b1;
						if (unit inside {[16'hDC00:16'hDFFF]}) begin
							mode_n = M_STR;
							hs_n   = 10'd0;
							cmd    = mk_cmd(OP_CP, ERR_NONE,
								{11'({1'b0, hs_q} + 11'd64), unit[9:0]});
						end else begin
							clr = 1'b1;
							cmd = mk_cmd(OP_ERR, ERR_BAD_SURR, 21'd0);
						end
					end
				end
			end
			M_WANT_BS: begin
				if (in_byte == 8'h5C) begin
					mode_n = M_WANT_U;
				end else begin
					has_cmd = 1'b1;
					clr     = 1'b1;
					cmd     = mk_cmd(OP_ERR, ERR_BAD_SURR, 21'd0);
				end
			end
			M_WANT_U: begin
				if (in_byte == 8'h75) begin
					mode_n = M_HEX2;
					acc_n  = 12'd0;
					cnt_n  = 2'd0;
				end else begin
					has_cmd = 1'b1;
					clr     = 1'b1;
					cmd     = mk_cmd(OP_ERR, ERR_BAD_SURR, 21'd0);
				end
			end
			default: clr = 1'b1;
		endcase
		if (clr) begin
			mode_n = M_IDLE;
			acc_n  = 12'd0;
			cnt_n  = 2'd0;
			hs_n   = 10'd0;
		end
	end

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && has_cmd;
	assign q_cmd    = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			acc_q  <= 12'd0;
			cnt_q  <= 2'd0;
			hs_q   <= 10'd0;
		end else if (accept) begin
			mode_q <= mode_n;
			acc_q  <= acc_n;
			cnt_q  <= cnt_n;
			hs_q   <= hs_n;
		end
	end

endmodule

[sv/jsu_queue.sv]
// Request queue between the parser front end and the output back end.
module jsu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jsu_pkg::cmd_t   wr_cmd,
	input  logic            pop,
	output jsu_pkg::cmd_t   rd_cmd,
	output jsu_pkg::qstat_t stat
);
	import jsu_pkg::*;

	cmd_t           entry_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign rd_cmd     = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == QCW'(QDEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

[sv/jsu_back.sv]
// Back end: expands queued requests into UTF-8 bytes and markers on the output.
module jsu_back (
	input  logic            clk,
	input  logic            arst_n,
	input  jsu_pkg::qstat_t q_stat,
	input  jsu_pkg::cmd_t   q_cmd,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic [1:0]      kind,
	output logic [2:0]      error_code,
	output logic            last
);
	import jsu_pkg::*;

	cmd_t        cur_q;
	logic        cur_valid_q;
	logic [1:0]  idx_q;
	logic [1:0]  nlast;
	logic [20:0] cp;
	logic [7:0]  byte_n;
	logic [1:0]  kind_n;
	logic        out_load, cur_done;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [1:0]  kind_q;
	logic [2:0]  err_q;
	logic        last_q;

	assign cp = cur_q.val;

	always_comb begin
		nlast = 2'd0;
		if (cur_q.op == OP_CP) begin
			if (cp <= 21'h7F) begin
				nlast = 2'd0;
			end else if (cp <= 21'h7FF) begin
				nlast = 2'd1;
			end else if (cp <= 21'hFFFF) begin
				nlast = 2'd2;
			end else begin
				nlast = 2'd3;
			end
		end
	end

	always_comb begin
		byte_n = 8'd0;
		kind_n = KIND_DATA;
		case (cur_q.op)
			OP_RAW: byte_n = cp[7:0];
			OP_CP: begin
				case ({nlast, idx_q})
					4'b00_00: byte_n = cp[7:0];
					4'b01_00: byte_n = {3'b110, cp[10:6]};
					4'b01_01: byte_n = {2'b10, cp[5:0]};
					4'b10_00: byte_n = {4'b1110, cp[15:12]};
					4'b10_01: byte_n = {2'b10, cp[11:6]};
					4'b10_10: byte_n = {2'b10, cp[5:0]};
					4'b11_00: byte_n = {5'b11110, cp[20:18]};
					4'b11_01: byte_n = {2'b10, cp[17:12]};
					4'b11_10: byte_n = {2'b10, cp[11:6]};
					4'b11_11: byte_n = {2'b10, cp[5:0]};
					default:  byte_n = 8'd0;
				endcase
			end
			OP_END: kind_n = KIND_END;
			OP_ERR: kind_n = KIND_ERR;
			default: kind_n = KIND_DATA;
		endcase
	end

	assign out_load = !out_valid_q || out_ready;
	assign cur_done = cur_valid_q && out_load && (idx_q == nlast);
	assign q_pop    = !q_stat.empty && (!cur_valid_q || cur_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (cur_done) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (cur_valid_q && out_load) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= cur_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && cur_valid_q) begin
			out_byte_q <= byte_n;
			kind_q     <= kind_n;
			err_q      <= (cur_q.op == OP_ERR) ? cur_q.err : ERR_NONE;
			last_q     <= (idx_q == nlast);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign kind       = kind_q;
	assign error_code = err_q;
	assign last       = last_q;

endmodule

[sv/json_string_unescape_utf8_unit.sv]
// Top level of the JSON string unescape unit: parser, request queue, UTF-8 output stage.
// Each result is held in the request queue, then in cur_q, then in the output register.
// Throughput: one input byte per cycle while the queue is not full; one result out per cycle unless out_ready stalls.
// A \u escape gives one to three bytes, a surrogate pair four; the back end emits one per cycle when not stalled.
// Input stalls only while the four-entry request queue is full.
// Reset clears the parser to idle, empties the queue and drops any pending output.
`include "json_string_unescape_utf8_unit_assert.svh"

module json_string_unescape_utf8_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic [2:0] error_code,
	output logic       last
);
	import jsu_pkg::*;

	qstat_t q_stat;
	cmd_t   push_cmd, head_cmd;
	logic   q_push, q_pop;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	jsu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (push_cmd),
		.pop    (q_pop),
		.rd_cmd (head_cmd),
		.stat   (q_stat)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.q_cmd      (head_cmd),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.kind       (kind),
		.error_code (error_code),
		.last       (last)
	);

	`JSU_ASSERT_IMPLY(a_no_overflow, q_push, !q_stat.full, "request pushed into full queue")
	`JSU_ASSERT_IMPLY(a_no_underflow, q_pop, !q_stat.empty, "request popped from empty queue")
	`JSU_ASSERT_IMPLY(a_marker_last, out_valid && kind != KIND_DATA, last, "marker without last")
	`JSU_ASSERT_IMPLY(a_err_code, out_valid && kind == KIND_ERR, error_code != ERR_NONE, "error without code")

endmodule

[sim/testbench.sv]
// Testbench for the JSON string unescape unit: directed byte table, then random JSON strings.
module testbench;
	import jsu_pkg::*;

	localparam int N_RANDOM = 390;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 20;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;

	typedef enum logic [3:0] {
		PM_IDLE, PM_STRING, PM_ESCAPE, PM_HEX_HIGH, PM_WANT_BSLASH, PM_WANT_U, PM_HEX_LOW
	} parse_mode_e;

	typedef enum logic [1:0] {ROW_SILENT, ROW_FIXED, ROW_MODEL} row_check_e;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic [2:0] code;
		logic       last;
	} utf8_res_t;

	typedef struct packed {
		logic [7:0] text;
		row_check_e check;
		utf8_res_t  res;
	} text_row_t;

	localparam utf8_res_t NO_RES = '0;
	localparam int N_DIRECTED = 40;
	localparam text_row_t DIRECTED [N_DIRECTED] = '{
		'{8'h00, ROW_FIXED,  '{8'h00, KIND_ERR,  ERR_NO_QUOTE, 1'b1}},
		'{8'h0D, ROW_SILENT, NO_RES},
		'{8'h22, ROW_SILENT, NO_RES},
		'{8'hFF, ROW_FIXED,  '{8'hFF, KIND_DATA, ERR_NONE, 1'b1}},
		'{8'h1F, ROW_FIXED,  '{8'h00, KIND_ERR,  ERR_CTRL, 1'b1}},
		'{8'h22, ROW_SILENT, NO_RES},
		'{8'h5C, ROW_SILENT, NO_RES},
		'{8'h62, ROW_FIXED,  '{8'h08, KIND_DATA, ERR_NONE, 1'b1}},
		'{8'h5C, ROW_SILENT, NO_RES},
		'{8'h75, ROW_SILENT, NO_RES},
		'{8'h44, ROW_SILENT, NO_RES},
		'{8'h62, ROW_SILENT, NO_RES},
		'{8'h46, ROW_SILENT, NO_RES},
		'{8'h66, ROW_SILENT, NO_RES},
		'{8'h5C, ROW_SILENT, NO_RES},
		'{8'h75, ROW_SILENT, NO_RES},
		'{8'h64, ROW_SILENT, NO_RES},
		'{8'h46, ROW_SILENT, NO_RES},
		'{8'h66, ROW_SILENT, NO_RES},
		'{8'h46, ROW_MODEL,  NO_RES},
		'{8'h22, ROW_FIXED,  '{8'h00, KIND_END,  ERR_NONE, 1'b1}},
		'{8'h22, ROW_SILENT, NO_RES},
		'{8'h5C, ROW_SILENT, NO_RES},
		'{8'h71, ROW_FIXED,  '{8'h00, KIND_ERR,  ERR_BAD_ESC, 1'b1}},
		'{8'h22, ROW_SILENT, NO_RES},
		'{8'h5C, ROW_SILENT, NO_RES},
		'{8'h75, ROW_SILENT, NO_RES},
		'{8'h30, ROW_SILENT, NO_RES},
		'{8'h30, ROW_SILENT, NO_RES},
		'{8'h30, ROW_SILENT, NO_RES},
		'{8'h30, ROW_FIXED,  '{8'h00, KIND_ERR,  ERR_NUL, 1'b1}},
		'{8'h22, ROW_SILENT, NO_RES},
		'{8'h5C, ROW_SILENT, NO_RES},
		'{8'h75, ROW_SILENT, NO_RES},
		'{8'h44, ROW_SILENT, NO_RES},
		'{8'h43, ROW_SILENT, NO_RES},
		'{8'h30, ROW_SILENT, NO_RES},
		'{8'h67, ROW_FIXED,  '{8'h00, KIND_ERR,  ERR_BAD_HEX, 1'b1}},
		'{8'h22, ROW_SILENT, NO_RES},
		'{8'h00, ROW_FIXED,  '{8'h00, KIND_ERR,  ERR_NUL, 1'b1}}
	};

	localparam logic [7:0] BLANKS [4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};
	localparam logic [7:0] SHORT_ESC [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
	localparam logic [15:0] BMP_EDGES [8] = '{
		16'h0001, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic [2:0] error_code;
	logic       last;

	parse_mode_e pmode;
	logic [15:0] hex_acc;
	logic [1:0]  hex_cnt;
	logic [9:0]  high_half;

	utf8_res_t  step_results[$];
	utf8_res_t  due_results[$];
	logic [7:0] text_q[$];

	bit calm;
	int err_cnt = 0;
	int n_bytes = 0;
	int n_checked = 0;
	int n_ends = 0;
	int n_errs = 0;
	int cycle_cnt = 0;

	json_string_unescape_utf8_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.kind       (kind),
		.error_code (error_code),
		.last       (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit is_blank(input logic [7:0] c);
		return c == BLANKS[0] || c == BLANKS[1] || c == BLANKS[2] || c == BLANKS[3];
	endfunction

	function automatic bit is_short_esc(input logic [7:0] c);
		foreach (SHORT_ESC[i])
			if (c == SHORT_ESC[i])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
		v = 4'h0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
			return 1'b1;
		end
		if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 10);
			return 1'b1;
		end
		if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void add_result(input logic [7:0] data, input logic [1:0] k,
			input logic [2:0] code, input logic lst);
		utf8_res_t r;
		r.data = data;
		r.kind = k;
		r.code = code;
		r.last = lst;
		step_results.push_back(r);
	endfunction

	function automatic void reset_parse();
		pmode = PM_IDLE;
		hex_acc = '0;
		hex_cnt = '0;
		high_half = '0;
	endfunction

	function automatic void parse_error(input logic [2:0] code);
		reset_parse();
		add_result(8'h00, KIND_ERR, code, 1'b1);
	endfunction

	function automatic void emit_code_point(input logic [20:0] cp);
		logic [7:0] b [4];
		int n;
		if (cp <= 21'h7F) begin
			b[0] = cp[7:0];
			n = 1;
		end else if (cp <= 21'h7FF) begin
			b[0] = {3'b110, cp[10:6]};
			b[1] = {2'b10, cp[5:0]};
			n = 2;
		end else if (cp <= 21'hFFFF) begin
			b[0] = {4'b1110, cp[15:12]};
			b[1] = {2'b10, cp[11:6]};
			b[2] = {2'b10, cp[5:0]};
			n = 3;
		end else begin
			b[0] = {5'b11110, cp[20:18]};
			b[1] = {2'b10, cp[17:12]};
			b[2] = {2'b10, cp[11:6]};
			b[3] = {2'b10, cp[5:0]};
			n = 4;
		end
		for (int i = 0; i < n; i++)
			add_result(b[i], KIND_DATA, ERR_NONE, i == n - 1);
		reset_parse();
		pmode = PM_STRING;
	endfunction

	function automatic void unescape_byte(input logic [7:0] c);
		logic [3:0]  nib;
		logic [15:0] unit;
		step_results.delete();
		case (pmode)
		PM_IDLE: begin
			if (c == CH_QUOTE)
				pmode = PM_STRING;
			else if (!is_blank(c))
				parse_error(ERR_NO_QUOTE);
		end
		PM_STRING: begin
			if (c == CH_NUL)
				parse_error(ERR_NUL);
			else if (c == CH_QUOTE) begin
				reset_parse();
				add_result(8'h00, KIND_END, ERR_NONE, 1'b1);
			end else if (c == CH_BSLASH)
				pmode = PM_ESCAPE;
			else if (c < 8'h20)
				parse_error(ERR_CTRL);
			else
				add_result(c, KIND_DATA, ERR_NONE, 1'b1);
		end
		PM_ESCAPE: begin
			pmode = PM_STRING;
			case (c)
			CH_NUL: parse_error(ERR_NUL);
			CH_QUOTE, CH_BSLASH, CH_SLASH: add_result(c, KIND_DATA, ERR_NONE, 1'b1);
			"b": add_result(8'h08, KIND_DATA, ERR_NONE, 1'b1);
			"f": add_result(8'h0C, KIND_DATA, ERR_NONE, 1'b1);
			"n": add_result(8'h0A, KIND_DATA, ERR_NONE, 1'b1);
			"r": add_result(8'h0D, KIND_DATA, ERR_NONE, 1'b1);
			"t": add_result(8'h09, KIND_DATA, ERR_NONE, 1'b1);
			CH_U: begin
				pmode = PM_HEX_HIGH;
				hex_acc = '0;
				hex_cnt = '0;
			end
			default: parse_error(ERR_BAD_ESC);
			endcase
		end
		PM_HEX_HIGH, PM_HEX_LOW: begin
			if (!hex_nibble(c, nib))
				parse_error(ERR_BAD_HEX);
			else begin
				hex_acc = {hex_acc[11:0], nib};
				if (hex_cnt != 2'd3)
					hex_cnt++;
				else begin
					unit = hex_acc;
					hex_acc = '0;
					hex_cnt = '0;
					if (pmode == PM_HEX_HIGH) begin
						if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
							high_half = unit[9:0];
							pmode = PM_WANT_BSLASH;
						end else if (unit >= 16'hDC00 && unit <= 16'hDFFF)
							parse_error(ERR_BAD_SURR);
						else if (unit == 16'h0000)
							parse_error(ERR_NUL);
						else
							emit_code_point({5'd0, unit});
					end else if (unit < 16'hDC00 || unit > 16'hDFFF)
						parse_error(ERR_BAD_SURR);
					else
						emit_code_point(21'h10000 + {high_half, unit[9:0]});
				end
			end
		end
		PM_WANT_BSLASH: begin
			if (c != CH_BSLASH)
				parse_error(ERR_BAD_SURR);
			else
				pmode = PM_WANT_U;
		end
		PM_WANT_U: begin
			if (c != CH_U)
				parse_error(ERR_BAD_SURR);
			else begin
				pmode = PM_HEX_LOW;
				hex_acc = '0;
				hex_cnt = '0;
			end
		end
		default: reset_parse();
		endcase
	endfunction

	function automatic void push_u();
		text_q.push_back(CH_BSLASH);
		text_q.push_back(CH_U);
	endfunction

	function automatic void push_hex(input logic [15:0] v);
		logic [3:0] nib;
		for (int i = 3; i >= 0; i--) begin
			nib = v[i*4 +: 4];
			if (nib < 4'd10)
				text_q.push_back(8'h30 + nib);
			else
				text_q.push_back(($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10);
		end
	endfunction

	function automatic logic [15:0] bmp_unit();
		case ($urandom_range(0, 4))
		0: return 16'($urandom_range(16'h0001, 16'h007F));
		1: return 16'($urandom_range(16'h0080, 16'h07FF));
		2: return 16'($urandom_range(16'h0800, 16'hD7FF));
		3: return 16'($urandom_range(16'hE000, 16'hFFFF));
		default: return BMP_EDGES[$urandom_range(0, 7)];
		endcase
	endfunction

	function automatic logic [15:0] high_unit();
		return 16'($urandom_range(16'hD800, 16'hDBFF));
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(8'h20, 8'hFF));
		while (c == CH_QUOTE || c == CH_BSLASH);
		return c;
	endfunction

	function automatic void add_fault();
		logic [7:0]  c;
		logic [3:0]  nib;
		logic [15:0] unit;
		case ($urandom_range(0, 9))
		0: text_q.push_back(8'($urandom_range(8'h01, 8'h1F)));
		1: text_q.push_back(CH_NUL);
		2: begin
			do
				c = 8'($urandom_range(1, 255));
			while (is_short_esc(c) || c == CH_U);
			text_q.push_back(CH_BSLASH);
			text_q.push_back(c);
		end
		3: begin
			text_q.push_back(CH_BSLASH);
			text_q.push_back(CH_NUL);
		end
		4: begin
			push_u();
			if ($urandom_range(0, 1)) begin
				push_hex(high_unit());
				push_u();
			end
			repeat ($urandom_range(0, 3))
				text_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
			do
				c = 8'($urandom_range(0, 255));
			while (hex_nibble(c, nib));
			text_q.push_back(c);
		end
		5: begin
			push_u();
			push_hex(16'($urandom_range(16'hDC00, 16'hDFFF)));
		end
		6: begin
			push_u();
			push_hex(high_unit());
			do
				c = 8'($urandom_range(0, 255));
			while (c == CH_BSLASH);
			text_q.push_back(c);
		end
		7: begin
			push_u();
			push_hex(high_unit());
			text_q.push_back(CH_BSLASH);
			do
				c = 8'($urandom_range(0, 255));
			while (c == CH_U);
			text_q.push_back(c);
		end
		8: begin
			push_u();
			push_hex(high_unit());
			push_u();
			do
				unit = 16'($urandom_range(0, 16'hFFFF));
			while (unit >= 16'hDC00 && unit <= 16'hDFFF);
			push_hex(unit);
		end
		default: begin
			push_u();
			push_hex(16'h0000);
		end
		endcase
	endfunction

	function automatic void build_text();
		text_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 4))
				text_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 2))
			text_q.push_back(BLANKS[$urandom_range(0, 3)]);
		text_q.push_back(CH_QUOTE);
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 5))
			2: begin
				text_q.push_back(CH_BSLASH);
				text_q.push_back(SHORT_ESC[$urandom_range(0, 7)]);
			end
			3: begin
				push_u();
				push_hex(bmp_unit());
			end
			4: begin
				push_u();
				push_hex(high_unit());
				push_u();
				push_hex(16'($urandom_range(16'hDC00, 16'hDFFF)));
			end
			default: text_q.push_back(plain_byte());
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			add_fault();
		else
			text_q.push_back(CH_QUOTE);
		if ($urandom_range(0, 19) == 0)
			text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
	endfunction

	task automatic send_byte(input logic [7:0] c, input row_check_e check, input utf8_res_t fixed);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= c;
		do
			@(posedge clk);
		while (!in_ready);
		n_bytes++;
		unescape_byte(c);
		if (check == ROW_MODEL) begin
			foreach (step_results[i])
				due_results.push_back(step_results[i]);
		end else if (check == ROW_FIXED)
			due_results.push_back(fixed);
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	always @(posedge clk) begin
		utf8_res_t want;
		if (arst_n && out_valid && out_ready) begin
			n_checked++;
			if (kind == KIND_END)
				n_ends++;
			if (kind == KIND_ERR)
				n_errs++;
			if (due_results.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("%0t: expected no result, got data=%h kind=%0d code=%0d last=%b",
						$time, out_byte, kind, error_code, last);
			end else begin
				want = due_results.pop_front();
				if (out_byte !== want.data || kind !== want.kind ||
						error_code !== want.code || last !== want.last) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t: expected data=%h kind=%0d code=%0d last=%b, got data=%h kind=%0d code=%0d last=%b",
							$time, want.data, want.kind, want.code, want.last,
							out_byte, kind, error_code, last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		calm = 1'b0;
		reset_parse();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++)
			send_byte(DIRECTED[i].text, DIRECTED[i].check, DIRECTED[i].res);
		while (n_bytes < N_DIRECTED + N_RANDOM) begin
			calm = ($urandom_range(0, 5) == 0);
			build_text();
			foreach (text_q[i])
				send_byte(text_q[i], ROW_MODEL, NO_RES);
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("fed %0d text bytes, checked %0d results (%0d string ends, %0d parse errors)",
			n_bytes, n_checked, n_ends, n_errs);
		$display("%0d mismatches", err_cnt);
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
